// File: src/mat4mul_pkg.sv
// mat4mul_pkg: shared constants, widths and inter-module structs for the
// fixed-point matrix multiplier. No dependencies.
`default_nettype none

package mat4mul_pkg;

  // Matrix geometry and number format
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;

  // Row/column index and per-lane store addressing (two banks of DIM rows)
  localparam int IDX_W     = $clog2(DIM);
  localparam int BANK_AW   = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << BANK_AW;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  // Arithmetic widths: exact products, exact sum plus room for rounding
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;
  localparam logic [ACC_W-1:0] ROUND_ADD = (ACC_W'(1) << FRAC_BITS) >> 1;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Element write from the front into the back's stores
  typedef struct packed {
    logic                     en;
    logic                     bank;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] left;
    logic signed [ELEM_W-1:0] right;
  } mm_wr_t;

  // Bank event: a loaded bank queued, or a bank handed back after its reads
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_msg_t;

endpackage

`default_nettype wire

// File: src/mat4mul_front.sv
// mat4mul_front: accepts input words, tracks row/column position and bank
// occupancy, and queues a job when a matrix pair is complete. Uses mat4mul_pkg.
`default_nettype none

module mat4mul_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [mat4mul_pkg::ELEM_W-1:0]  in_left_element,
  input  wire logic signed [mat4mul_pkg::ELEM_W-1:0]  in_right_element,
  output mat4mul_pkg::mm_wr_t                         wr,
  output mat4mul_pkg::bank_msg_t                      push,
  input  wire mat4mul_pkg::bank_msg_t                 rel
);
  import mat4mul_pkg::*;

  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       bank_full_r, bank_full_nxt;
  logic             accept;
  logic             last_word;

  // Stall while the bank being loaded still holds an unfinished job
  assign busy      = bank_full_r[bank_r];
  assign accept    = start & ~busy;
  assign last_word = accept && (row_r == IDX_LAST) && (col_r == IDX_LAST);

  // Forward the word to the stores at its row/column in the current bank
  always_comb begin
    wr.en    = accept;
    wr.bank  = bank_r;
    wr.row   = row_r;
    wr.col   = col_r;
    wr.left  = in_left_element;
    wr.right = in_right_element;
  end

  // Queue the bank once its last word is in
  always_comb begin
    push.valid = last_word;
    push.bank  = bank_r;
  end

  // Advance position, flip bank at end of a matrix pair, track occupancy
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    bank_nxt      = bank_r;
    bank_full_nxt = bank_full_r;
    if (rel.valid) begin
      bank_full_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (col_r == IDX_LAST) begin
        col_nxt = '0;
        if (row_r == IDX_LAST) begin
          row_nxt                = '0;
          bank_nxt               = ~bank_r;
          bank_full_nxt[bank_r]  = 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      bank_r      <= 1'b0;
      bank_full_r <= '0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      bank_r      <= bank_nxt;
      bank_full_r <= bank_full_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/mat4mul_job_queue.sv
// mat4mul_job_queue: short FIFO of loaded bank numbers between the front and
// the compute back end. Uses mat4mul_pkg.
`default_nettype none

module mat4mul_job_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mat4mul_pkg::bank_msg_t  push,
  input  wire logic                    pop,
  output logic                         head_valid,
  output logic                         head_bank
);
  import mat4mul_pkg::*;

  logic              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign head_valid = (count_r != '0);
  assign head_bank  = entry_r[rptr_r];
  assign do_pop     = pop & head_valid;

  // Advance pointers and count
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push.valid) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the entries
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wptr_r] <= push.bank;
    end
  end

endmodule

`default_nettype wire

// File: src/mat4mul_back.sv
// mat4mul_back: per-lane element stores, read sequencer and the multiply /
// sum / round-and-saturate pipeline that emits product words. Uses mat4mul_pkg.
`default_nettype none

module mat4mul_back (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire mat4mul_pkg::mm_wr_t                    wr,
  input  wire logic                                   job_valid,
  input  wire logic                                   job_bank,
  output logic                                        job_pop,
  output mat4mul_pkg::bank_msg_t                      rel,
  output logic                                        out_valid,
  output logic signed [mat4mul_pkg::ELEM_W-1:0]       out_product_element,
  output logic                                        out_last_of_run,
  output logic                                        out_saturated
);
  import mat4mul_pkg::*;

  // Read sequencer
  logic             active_r, active_nxt;
  logic             bank_act_r, bank_act_nxt;
  logic [IDX_W-1:0] irow_r, irow_nxt;
  logic [IDX_W-1:0] icol_r, icol_nxt;
  logic             issue_last;

  // Pipeline
  logic                     s1_v_r, s1_last_r;
  logic                     s2_v_r, s2_last_r;
  logic                     s3_v_r, s3_last_r;
  logic signed [ELEM_W-1:0] lrd_r [DIM];
  logic signed [ELEM_W-1:0] rrd_r [DIM];
  logic signed [PROD_W-1:0] prod_r [DIM];
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]  scaled;
  logic                     hi_ones;
  logic                     hi_zeros;

  logic                     out_valid_r;
  logic                     out_last_r;
  logic                     out_sat_r;
  logic signed [ELEM_W-1:0] out_elem_r;

  assign job_pop    = ~active_r & job_valid;
  assign issue_last = active_r && (irow_r == IDX_LAST) && (icol_r == IDX_LAST);

  // Hand the bank back once its final reads are issued
  always_comb begin
    rel.valid = issue_last;
    rel.bank  = bank_act_r;
  end

  // Walk result cells in row-major order, one per cycle
  always_comb begin
    active_nxt   = active_r;
    bank_act_nxt = bank_act_r;
    irow_nxt     = irow_r;
    icol_nxt     = icol_r;
    if (job_pop) begin
      active_nxt   = 1'b1;
      bank_act_nxt = job_bank;
      irow_nxt     = '0;
      icol_nxt     = '0;
    end else if (active_r) begin
      if (icol_r == IDX_LAST) begin
        icol_nxt = '0;
        if (irow_r == IDX_LAST) begin
          irow_nxt   = '0;
          active_nxt = 1'b0;
        end else begin
          irow_nxt = irow_r + 1'b1;
        end
      end else begin
        icol_nxt = icol_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      bank_act_r <= 1'b0;
      irow_r     <= '0;
      icol_r     <= '0;
    end else begin
      active_r   <= active_nxt;
      bank_act_r <= bank_act_nxt;
      irow_r     <= irow_nxt;
      icol_r     <= icol_nxt;
    end
  end

  // Lane k stores left column k by row, and right row k by column
  for (genvar k = 0; k < DIM; k++) begin : g_lane
    logic signed [ELEM_W-1:0] left_mem  [MEM_DEPTH];
    logic signed [ELEM_W-1:0] right_mem [MEM_DEPTH];

    always_ff @(posedge clk) begin
      if (wr.en && (wr.col == IDX_W'(k))) begin
        left_mem[{wr.bank, wr.row}] <= wr.left;
      end
      if (active_r) begin
        lrd_r[k] <= left_mem[{bank_act_r, irow_r}];
      end
    end

    always_ff @(posedge clk) begin
      if (wr.en && (wr.row == IDX_W'(k))) begin
        right_mem[{wr.bank, wr.col}] <= wr.right;
      end
      if (active_r) begin
        rrd_r[k] <= right_mem[{bank_act_r, icol_r}];
      end
    end

    // Multiply one term per lane
    always_ff @(posedge clk) begin
      prod_r[k] <= lrd_r[k] * rrd_r[k];
    end
  end

  // Sum the lane products exactly
  always_comb begin
    acc_sum = '0;
    for (int k = 0; k < DIM; k++) begin
      acc_sum = acc_sum + ACC_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_sum;
  end

  // Round to nearest (ties up), rescale, then clip to the element range
  assign rnd_sum  = acc_r + $signed(ROUND_ADD);
  assign scaled   = rnd_sum >>> FRAC_BITS;
  assign hi_ones  = &scaled[ACC_W-1:ELEM_W-1];
  assign hi_zeros = ~|scaled[ACC_W-1:ELEM_W-1];

  always_ff @(posedge clk) begin
    if (hi_ones || hi_zeros) begin
      out_elem_r <= scaled[ELEM_W-1:0];
      out_sat_r  <= 1'b0;
    end else if (scaled[ACC_W-1]) begin
      out_elem_r <= {1'b1, {(ELEM_W-1){1'b0}}};
      out_sat_r  <= 1'b1;
    end else begin
      out_elem_r <= {1'b0, {(ELEM_W-1){1'b1}}};
      out_sat_r  <= 1'b1;
    end
    out_last_r <= s3_last_r;
  end

  // Advance valid and last markers alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_v_r      <= 1'b0;
      s2_last_r   <= 1'b0;
      s3_v_r      <= 1'b0;
      s3_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= active_r;
      s1_last_r   <= issue_last;
      s2_v_r      <= s1_v_r;
      s2_last_r   <= s1_last_r;
      s3_v_r      <= s2_v_r;
      s3_last_r   <= s2_last_r;
      out_valid_r <= s3_v_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_product_element = out_elem_r;
  assign out_last_of_run     = out_last_r;
  assign out_saturated       = out_sat_r;

endmodule

`default_nettype wire

// File: src/matrix4x4_multiply.sv
// matrix4x4_multiply: top level of the streaming Q16.16 4x4 matrix multiplier.
// Depends on mat4mul_pkg, mat4mul_front, mat4mul_job_queue, mat4mul_back.
//
// Load one word per cycle (start high while busy is low): element n of the
// left and right matrices, in row-major order. After the sixteenth word the
// block emits the sixteen product words in row-major order, one per cycle,
// each marked by out_valid for one cycle, with out_last_of_run on the final
// one. The receiver cannot stall the block, so take every word in the cycle
// it is shown. The element stores are double-banked: the next matrix pair
// loads while the previous one is computed, four multiply lanes produce one
// product element per cycle, so the block sustains about one input word per
// cycle. busy rises only when both banks hold pairs not yet read out.
`default_nettype none

module matrix4x4_multiply (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [mat4mul_pkg::ELEM_W-1:0]  in_left_element,
  input  wire logic signed [mat4mul_pkg::ELEM_W-1:0]  in_right_element,
  output logic                                        out_valid,
  output logic signed [mat4mul_pkg::ELEM_W-1:0]       out_product_element,
  output logic                                        out_last_of_run,
  output logic                                        out_saturated
);
  import mat4mul_pkg::*;

  mm_wr_t    wr;
  bank_msg_t push;
  bank_msg_t rel;
  logic      job_valid;
  logic      job_bank;
  logic      job_pop;

  mat4mul_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_left_element  (in_left_element),
    .in_right_element (in_right_element),
    .wr               (wr),
    .push             (push),
    .rel              (rel)
  );

  mat4mul_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_bank  (job_bank)
  );

  mat4mul_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .wr                  (wr),
    .job_valid           (job_valid),
    .job_bank            (job_bank),
    .job_pop             (job_pop),
    .rel                 (rel),
    .out_valid           (out_valid),
    .out_product_element (out_product_element),
    .out_last_of_run     (out_last_of_run),
    .out_saturated       (out_saturated)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for matrix4x4_multiply, the streaming Q16.16
// 4x4 matrix multiplier. Depends on mat4mul_pkg and the matrix4x4_multiply RTL.
// Words are loaded under start/busy and product words are checked against a predictor.
module tb_top;
  import mat4mul_pkg::*;

  localparam int CELL_COUNT   = DIM * DIM;
  localparam int SUM_W        = 2 * ELEM_W + 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [SUM_W-1:0] SUM_ONE  = 1;
  localparam logic signed [SUM_W-1:0] CLIP_MAX = (SUM_ONE <<< (ELEM_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0] CLIP_MIN = -(SUM_ONE <<< (ELEM_W - 1));

  localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] Q_ONE    = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] Q_HALF   = 32'h0000_8000;
  localparam logic [ELEM_W-1:0] Q_NHALF  = 32'hFFFF_8000;
  localparam logic [ELEM_W-1:0] Q_NLSB   = 32'hFFFF_FFFF;

  // How the elements of one matrix pair are drawn
  typedef enum int {
    FILL_FULL,
    FILL_UNIT,
    FILL_NEAR_LIMIT,
    FILL_EXTREME,
    FILL_MIXED
  } fill_mode_t;

  typedef struct {
    logic signed [ELEM_W-1:0] product;
    logic                     last;
    logic                     sat;
  } product_word_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [ELEM_W-1:0] in_left_element;
  logic signed [ELEM_W-1:0] in_right_element;
  logic                     out_valid;
  logic signed [ELEM_W-1:0] out_product_element;
  logic                     out_last_of_run;
  logic                     out_saturated;

  // Predictor state: loaded elements and the expected product words
  logic signed [ELEM_W-1:0] left_cells [CELL_COUNT];
  logic signed [ELEM_W-1:0] right_cells [CELL_COUNT];
  int                       cells_loaded;
  product_word_t            pending_products [$];
  int                       error_count;
  int                       cycle_count;

  matrix4x4_multiply dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_left_element     (in_left_element),
    .in_right_element    (in_right_element),
    .out_valid           (out_valid),
    .out_product_element (out_product_element),
    .out_last_of_run     (out_last_of_run),
    .out_saturated       (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Store one accepted pair; on the last cell form the whole product
  function automatic void load_pair(input logic signed [ELEM_W-1:0] lhs,
                                     input logic signed [ELEM_W-1:0] rhs);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
    product_word_t           word;
    left_cells[cells_loaded]  = lhs;
    right_cells[cells_loaded] = rhs;
    cells_loaded++;
    if (cells_loaded < CELL_COUNT) return;
    cells_loaded = 0;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        sum = '0;
        for (int k = 0; k < DIM; k++) begin
          a   = left_cells[i * DIM + k];
          b   = right_cells[k * DIM + j];
          sum = sum + a * b;
        end
        // round half up, then drop the fraction bits
        if (FRAC_BITS > 0) sum = sum + (SUM_ONE <<< (FRAC_BITS - 1));
        sum = sum >>> FRAC_BITS;
        word.sat = 1'b1;
        if (sum > CLIP_MAX) word.product = ELEM_MAX;
        else if (sum < CLIP_MIN) word.product = ELEM_MIN;
        else begin
          word.product = sum[ELEM_W-1:0];
          word.sat     = 1'b0;
        end
        word.last = (i == DIM - 1) && (j == DIM - 1);
        pending_products.push_back(word);
      end
    end
  endfunction

  function automatic logic [ELEM_W-1:0] draw_element(input fill_mode_t mode);
    logic [ELEM_W-1:0] raw;
    fill_mode_t        pick;
    raw  = $urandom();
    pick = mode;
    if (pick == FILL_MIXED) pick = fill_mode_t'($urandom_range(0, 3));
    case (pick)
      FILL_UNIT:       return {{14{raw[17]}}, raw[17:0]};
      FILL_NEAR_LIMIT: return {{8{raw[23]}}, raw[23:0]};
      FILL_EXTREME: begin
        case ($urandom_range(0, 7))
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return '0;
          3: return 32'h0000_0001;
          4: return Q_NLSB;
          5: return Q_HALF;
          6: return Q_NHALF;
          default: return Q_ONE;
        endcase
      end
      default: return raw;
    endcase
  endfunction

  // Present one word and hold it until the block takes it
  task automatic send_pair(input logic signed [ELEM_W-1:0] lhs,
                           input logic signed [ELEM_W-1:0] rhs);
    @(negedge clk);
    in_left_element  <= lhs;
    in_right_element <= rhs;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    load_pair(lhs, rhs);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Saturation both ways, rounding ties both signs, identity-like rows
  task automatic test_saturation_and_rounding();
    logic [ELEM_W-1:0] lhs [CELL_COUNT];
    logic [ELEM_W-1:0] rhs [CELL_COUNT];
    lhs = '{ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
            ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
            32'h0000_0001, '0, '0, '0,
            Q_NLSB, Q_ONE, '0, Q_HALF};
    rhs = '{ELEM_MAX, ELEM_MIN, Q_HALF, Q_NHALF,
            ELEM_MAX, ELEM_MIN, '0, Q_ONE,
            ELEM_MAX, ELEM_MIN, Q_NLSB, '0,
            ELEM_MAX, ELEM_MIN, 32'h0000_0001, Q_NHALF};
    for (int n = 0; n < CELL_COUNT; n++) send_pair(lhs[n], rhs[n]);
  endtask

  // Random matrix pairs with bursts of sender idling on some of them
  task automatic test_random_with_gaps(input int pairs);
    fill_mode_t mode;
    bit         gappy;
    for (int m = 0; m < pairs; m++) begin
      mode  = fill_mode_t'($urandom_range(0, 4));
      gappy = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < CELL_COUNT; n++) begin
        send_pair(draw_element(mode), draw_element(mode));
        if (gappy && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 19));
      end
    end
  endtask

  // Random matrix pairs loaded back to back, no idling
  task automatic test_back_to_back(input int pairs);
    fill_mode_t mode;
    for (int m = 0; m < pairs; m++) begin
      mode = fill_mode_t'($urandom_range(0, 4));
      for (int n = 0; n < CELL_COUNT; n++) send_pair(draw_element(mode), draw_element(mode));
    end
  endtask

  // Check every product word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_products.size() == 0) begin
        $error("unexpected product word: product_element %0d", out_product_element);
        error_count++;
      end else begin
        product_word_t want;
        want = pending_products.pop_front();
        if (out_product_element !== want.product) begin
          $error("product_element: expected %0d, got %0d", want.product,
                 out_product_element);
          error_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_left_element  = '0;
    in_right_element = '0;
    cells_loaded     = 0;
    error_count      = 0;
    cycle_count      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_saturation_and_rounding();
    test_random_with_gaps(8);
    test_back_to_back(4);

    // Drop start, drain, then watch for stray words
    @(negedge clk);
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
